// File: sv/prqf_pkg.sv
// ----------------------------------------------------------------------------
// prqf_pkg
// Shared types and constants of the paired read quality filter.
// ----------------------------------------------------------------------------
package prqf_pkg;

  localparam int CHAR_W   = 8;
  localparam int QUAL_W   = 7;
  localparam int THR_W    = 16;
  localparam int FRAC_W   = 16;
  localparam int PAIR_W   = 48;
  localparam int CFG_IDX_W = 3;

  localparam logic [PAIR_W-1:0] PAIR_MAX = {PAIR_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_QUALITY_OFFSET     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_QUALITY_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_IS_COUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_THRESHOLD    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRACTION_Q16       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_LIMIT         = 3'd5;

  typedef struct packed {
    logic [QUAL_W-1:0] quality_offset;
    logic [QUAL_W-1:0] low_quality_limit;
    logic              threshold_is_count;
    logic [THR_W-1:0]  count_threshold;
    logic [FRAC_W-1:0] fraction_q16;
    logic [PAIR_W-1:0] pair_limit;
  } cfg_t;

  typedef struct packed {
    logic              mate;
    logic [PAIR_W-1:0] pair_total;
    logic              limit_reached;
  } pair_info_t;

endpackage

// File: sv/prqf_item_if.sv
// ----------------------------------------------------------------------------
// prqf_item_if
// Request channel carrying one quality character with its mate and end mark.
// ----------------------------------------------------------------------------
interface prqf_item_if;
  logic                          valid;
  logic                          ready;
  logic [prqf_pkg::CHAR_W-1:0]   quality_char;
  logic                          mate;
  logic                          read_end;

  modport source (output valid, output quality_char, output mate, output read_end,
                  input ready);
  modport sink   (input valid, input quality_char, input mate, input read_end,
                  output ready);
endinterface

// File: sv/prqf_result_if.sv
// ----------------------------------------------------------------------------
// prqf_result_if
// Result channel carrying the pair verdict and running totals.
// ----------------------------------------------------------------------------
interface prqf_result_if;
  logic                          valid;
  logic                          ready;
  logic                          pair_is_low;
  logic [prqf_pkg::PAIR_W-1:0]   low_pair_total;
  logic [prqf_pkg::PAIR_W-1:0]   pair_total;
  logic                          limit_reached;

  modport source (output valid, output pair_is_low, output low_pair_total,
                  output pair_total, output limit_reached, input ready);
  modport sink   (input valid, input pair_is_low, input low_pair_total,
                  input pair_total, input limit_reached, output ready);
endinterface

// File: sv/prqf_cfg_if.sv
// ----------------------------------------------------------------------------
// prqf_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface prqf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [prqf_pkg::CFG_IDX_W-1:0]  index;
  logic [prqf_pkg::PAIR_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/prqf_cfg_regs.sv
// ----------------------------------------------------------------------------
// prqf_cfg_regs
// Configuration register bank, written one register per request.
// ----------------------------------------------------------------------------
module prqf_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  prqf_cfg_if.sink           cfg,
  output prqf_pkg::cfg_t     regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.quality_offset     <= 7'd33;
      regs.low_quality_limit  <= 7'd5;
      regs.threshold_is_count <= 1'b0;
      regs.count_threshold    <= 16'd1;
      regs.fraction_q16       <= 16'd32768;
      regs.pair_limit         <= 48'd1000000;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        prqf_pkg::REG_QUALITY_OFFSET:
          regs.quality_offset <= cfg.data[prqf_pkg::QUAL_W-1:0];
        prqf_pkg::REG_LOW_QUALITY_LIMIT:
          regs.low_quality_limit <= cfg.data[prqf_pkg::QUAL_W-1:0];
        prqf_pkg::REG_THRESHOLD_IS_COUNT:
          regs.threshold_is_count <= cfg.data[0];
        prqf_pkg::REG_COUNT_THRESHOLD:
          regs.count_threshold <= cfg.data[prqf_pkg::THR_W-1:0];
        prqf_pkg::REG_FRACTION_Q16:
          regs.fraction_q16 <= cfg.data[prqf_pkg::FRAC_W-1:0];
        prqf_pkg::REG_PAIR_LIMIT:
          regs.pair_limit <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// File: sv/prqf_read_count.sv
// ----------------------------------------------------------------------------
// prqf_read_count
// Input register, per-read base counters and pair count; hands finished
// reads on to the verdict stage.
// ----------------------------------------------------------------------------
module prqf_read_count #(
  parameter int READ_COUNT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  prqf_item_if.sink                   item,
  input  prqf_pkg::cfg_t              cfg,
  output logic                        hand_valid,
  input  logic                        hand_ready,
  output logic [READ_COUNT_BITS-1:0]  hand_bases,
  output logic [READ_COUNT_BITS-1:0]  hand_lows,
  output prqf_pkg::pair_info_t        hand_info
);

  localparam logic [READ_COUNT_BITS-1:0] CNT_MAX = {READ_COUNT_BITS{1'b1}};

  logic                              s1_valid;
  logic [prqf_pkg::CHAR_W-1:0]       s1_char;
  logic                              s1_mate;
  logic                              s1_end;
  logic [READ_COUNT_BITS-1:0]        base_counter;
  logic [READ_COUNT_BITS-1:0]        low_base_counter;
  logic [prqf_pkg::PAIR_W-1:0]       pairs_seen;

  logic [READ_COUNT_BITS-1:0]        base_counter_next;
  logic [READ_COUNT_BITS-1:0]        low_base_counter_next;
  logic [prqf_pkg::PAIR_W-1:0]       pairs_seen_next;
  logic [prqf_pkg::CHAR_W:0]         low_bound;
  logic                              base_low;
  logic                              ignore;
  logic                              s1_move;

  always_comb begin
    ignore    = pairs_seen >= cfg.pair_limit;
    low_bound = {2'b00, cfg.quality_offset} + {2'b00, cfg.low_quality_limit};
    base_low  = {1'b0, s1_char} <= low_bound;

    base_counter_next = (base_counter == CNT_MAX) ? base_counter
                                                  : base_counter + 1'b1;
    low_base_counter_next = low_base_counter;
    if (base_low && low_base_counter != CNT_MAX) begin
      low_base_counter_next = low_base_counter + 1'b1;
    end

    pairs_seen_next = pairs_seen;
    if (s1_end && s1_mate && pairs_seen != prqf_pkg::PAIR_MAX) begin
      pairs_seen_next = pairs_seen + 1'b1;
    end

    hand_valid               = s1_valid && !ignore && s1_end;
    hand_bases               = base_counter_next;
    hand_lows                = low_base_counter_next;
    hand_info.mate           = s1_mate;
    hand_info.pair_total     = pairs_seen_next;
    hand_info.limit_reached  = pairs_seen_next >= cfg.pair_limit;

    s1_move = s1_valid && (!hand_valid || hand_ready);
  end

  assign item.ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid         <= 1'b0;
      base_counter     <= '0;
      low_base_counter <= '0;
      pairs_seen       <= '0;
    end else begin
      if (item.ready) begin
        s1_valid <= item.valid;
      end
      if (s1_move && !ignore) begin
        if (s1_end) begin
          base_counter     <= '0;
          low_base_counter <= '0;
        end else begin
          base_counter     <= base_counter_next;
          low_base_counter <= low_base_counter_next;
        end
        pairs_seen <= pairs_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      s1_char <= item.quality_char;
      s1_mate <= item.mate;
      s1_end  <= item.read_end;
    end
  end

endmodule

// File: sv/prqf_verdict.sv
// ----------------------------------------------------------------------------
// prqf_verdict
// Read verdict against the count or fraction threshold, pair verdict, low
// pair count and the result register.
// ----------------------------------------------------------------------------
module prqf_verdict #(
  parameter int READ_COUNT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  prqf_pkg::cfg_t              cfg,
  input  logic                        hand_valid,
  output logic                        hand_ready,
  input  logic [READ_COUNT_BITS-1:0]  hand_bases,
  input  logic [READ_COUNT_BITS-1:0]  hand_lows,
  input  prqf_pkg::pair_info_t        hand_info,
  prqf_result_if.source               result
);

  localparam int PROD_W = READ_COUNT_BITS + prqf_pkg::FRAC_W;
  localparam int CMP_W  = (READ_COUNT_BITS > prqf_pkg::THR_W) ? READ_COUNT_BITS
                                                              : prqf_pkg::THR_W;

  logic                              s2_valid;
  logic [READ_COUNT_BITS-1:0]        s2_bases;
  logic [READ_COUNT_BITS-1:0]        s2_lows;
  prqf_pkg::pair_info_t              s2_info;
  logic                              first_mate_low;
  logic [prqf_pkg::PAIR_W-1:0]       low_pairs_seen;
  logic                              out_valid;
  logic                              out_low;
  logic [prqf_pkg::PAIR_W-1:0]       out_low_total;
  logic [prqf_pkg::PAIR_W-1:0]       out_total;
  logic                              out_limit;

  logic [PROD_W-1:0]                 prod;
  logic                              read_low;
  logic                              pair_low;
  logic [prqf_pkg::PAIR_W-1:0]       low_pairs_seen_next;
  logic                              out_free;
  logic                              s2_move;

  always_comb begin
    prod = PROD_W'(s2_bases) * PROD_W'(cfg.fraction_q16);
    if (cfg.threshold_is_count) begin
      read_low = CMP_W'(s2_lows) > CMP_W'(cfg.count_threshold);
    end else begin
      read_low = s2_lows > prod[PROD_W-1:prqf_pkg::FRAC_W];
    end
    pair_low = read_low || first_mate_low;

    low_pairs_seen_next = low_pairs_seen;
    if (pair_low && low_pairs_seen != prqf_pkg::PAIR_MAX) begin
      low_pairs_seen_next = low_pairs_seen + 1'b1;
    end

    out_free   = !out_valid || result.ready;
    s2_move    = s2_valid && (!s2_info.mate || out_free);
    hand_ready = !s2_valid || s2_move;
  end

  assign result.valid          = out_valid;
  assign result.pair_is_low    = out_low;
  assign result.low_pair_total = out_low_total;
  assign result.pair_total     = out_total;
  assign result.limit_reached  = out_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid       <= 1'b0;
      out_valid      <= 1'b0;
      first_mate_low <= 1'b0;
      low_pairs_seen <= '0;
    end else begin
      if (hand_ready) begin
        s2_valid <= hand_valid;
      end
      if (out_free) begin
        out_valid <= s2_move && s2_info.mate;
      end
      if (s2_move) begin
        if (s2_info.mate) begin
          first_mate_low <= 1'b0;
          low_pairs_seen <= low_pairs_seen_next;
        end else begin
          first_mate_low <= read_low;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hand_ready && hand_valid) begin
      s2_bases <= hand_bases;
      s2_lows  <= hand_lows;
      s2_info  <= hand_info;
    end
    if (s2_move && s2_info.mate) begin
      out_low       <= pair_low;
      out_low_total <= low_pairs_seen_next;
      out_total     <= s2_info.pair_total;
      out_limit     <= s2_info.limit_reached;
    end
  end

endmodule

// File: sv/paired_read_quality_filter.sv
// ----------------------------------------------------------------------------
// paired_read_quality_filter
// Counts low-quality bases per read of a pair and reports the pair verdict
// with running totals at the end of each second mate.
// ----------------------------------------------------------------------------
// One quality character is taken per cycle, with no gaps, for as long as the
// result side keeps up. A character passes an input register, where the base
// counters and the pair count advance; the last character of a read goes on
// to a verdict register, where the read threshold (one READ_COUNT_BITS by 16
// multiply and compare) and the low pair count are worked out, and the end of
// a second mate then to the result register. Only the end of a second mate
// needs a result slot, so a stalled result side holds the pipeline only when
// such a read reaches it. No clearing pass follows reset. Once the pair total
// has reached pair_limit, characters are taken and dropped without effect.
// ----------------------------------------------------------------------------
module paired_read_quality_filter #(
  parameter int READ_COUNT_BITS = 16
) (
  input  logic            clk,
  input  logic            rst,
  prqf_cfg_if.sink        cfg,
  prqf_item_if.sink       item,
  prqf_result_if.source   result
);

  prqf_pkg::cfg_t                regs;
  logic                          hand_valid;
  logic                          hand_ready;
  logic [READ_COUNT_BITS-1:0]    hand_bases;
  logic [READ_COUNT_BITS-1:0]    hand_lows;
  prqf_pkg::pair_info_t          hand_info;

  prqf_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  prqf_read_count #(
    .READ_COUNT_BITS (READ_COUNT_BITS)
  ) u_read_count (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .cfg        (regs),
    .hand_valid (hand_valid),
    .hand_ready (hand_ready),
    .hand_bases (hand_bases),
    .hand_lows  (hand_lows),
    .hand_info  (hand_info)
  );

  prqf_verdict #(
    .READ_COUNT_BITS (READ_COUNT_BITS)
  ) u_verdict (
    .clk        (clk),
    .rst        (rst),
    .cfg        (regs),
    .hand_valid (hand_valid),
    .hand_ready (hand_ready),
    .hand_bases (hand_bases),
    .hand_lows  (hand_lows),
    .hand_info  (hand_info),
    .result     (result)
  );

  a_result_total_nonzero: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.pair_total != '0)
    else $error("result with zero pair total");

  a_low_within_total: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.low_pair_total <= result.pair_total)
    else $error("low pair total exceeds pair total");

  a_read_never_empty: assert property (@(posedge clk) disable iff (rst)
    hand_valid |-> hand_bases != '0 && hand_lows <= hand_bases)
    else $error("finished read with inconsistent counts");

  a_handoff_holds: assert property (@(posedge clk) disable iff (rst)
    hand_valid && !hand_ready |=> hand_valid && $stable(hand_bases)
      && $stable(hand_lows))
    else $error("stalled read handoff changed");

endmodule

// File: test/tb_paired_read_quality_filter.sv
// ----------------------------------------------------------------------------
// tb_paired_read_quality_filter
// Self-checking bench for the paired read quality filter. A directed table
// covers reset values, the register extremes and the mate-order cases.
// Random pairs and noise under changing settings follow, and finally a run
// up to a low pair limit, past it, and on after the limit is lifted.
// Every pair result is checked: a typed table row gives its own expected
// values, all others come from an in-bench model of the per-read counts
// and pair totals. Random stalls run on both request and result sides.
// ----------------------------------------------------------------------------
module tb_paired_read_quality_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHAR_W = prqf_pkg::CHAR_W;
  localparam int PAIR_W = prqf_pkg::PAIR_W;
  localparam int CFG_IDX_W = prqf_pkg::CFG_IDX_W;
  localparam int READ_BITS = 16;
  localparam logic [READ_BITS-1:0] READ_MAX = {READ_BITS{1'b1}};
  localparam int N_ROWS = 27;
  localparam int PHASE_ITEMS = 120;
  localparam int LONG_HOLD = 300;
  localparam int QUIET_LIMIT = 3000;
  localparam int LIMIT_PAIRS = 10000;
  localparam int LIMIT_STEP = 30;

  typedef struct packed {
    logic              pair_is_low;
    logic [PAIR_W-1:0] low_pair_total;
    logic [PAIR_W-1:0] pair_total;
    logic              limit_reached;
  } pair_result_t;

  typedef enum logic {ROW_CHAR, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [PAIR_W-1:0]    data;
    logic [CHAR_W-1:0]    qc;
    logic                 mate;
    logic                 rend;
    logic                 typed;
    pair_result_t         want;
  } stim_row_t;

  logic clk;
  logic rst;

  prqf_item_if   item_ch ();
  prqf_result_if result_ch ();
  prqf_cfg_if    cfg_ch ();

  paired_read_quality_filter #(.READ_COUNT_BITS(READ_BITS)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .item   (item_ch),
    .result (result_ch)
  );

  // model state
  prqf_pkg::cfg_t model_cfg = '{quality_offset: 7'd33, low_quality_limit: 7'd5,
                                threshold_is_count: 1'b0, count_threshold: 16'd1,
                                fraction_q16: 16'd32768, pair_limit: 48'd1000000};
  logic [READ_BITS-1:0] read_bases = '0;
  logic [READ_BITS-1:0] low_count = '0;
  logic                 mate0_low = 1'b0;
  logic [PAIR_W-1:0]    pair_count = '0;
  logic [PAIR_W-1:0]    low_pair_count = '0;

  pair_result_t verdict_q[$];
  logic         row_typed;
  pair_result_t row_want;

  bit src_gaps = 1'b1;
  bit sink_gaps = 1'b1;
  bit hold_req = 1'b0;
  int errors = 0;
  int quiet = 0;
  int n_items = 0;
  int n_results = 0;
  int n_low = 0;
  int n_regs = 0;

  stim_row_t stim_rows [N_ROWS];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic score_char(input logic [CHAR_W-1:0] qc, input logic m,
                                      input logic e, output pair_result_t res);
    int          diff;
    logic        verdict;
    logic [63:0] prod;
    res = '0;
    if (pair_count >= model_cfg.pair_limit) return 1'b0;
    if (read_bases != READ_MAX) read_bases++;
    diff = int'(qc) - int'(model_cfg.quality_offset);
    if (diff <= int'(model_cfg.low_quality_limit) && low_count != READ_MAX) low_count++;
    if (!e) return 1'b0;
    if (model_cfg.threshold_is_count) begin
      verdict = low_count > model_cfg.count_threshold;
    end else begin
      prod = 64'(read_bases) * 64'(model_cfg.fraction_q16);
      verdict = 64'(low_count) > (prod >> 16);
    end
    read_bases = '0;
    low_count = '0;
    if (!m) begin
      mate0_low = verdict;
      return 1'b0;
    end
    verdict = verdict | mate0_low;
    mate0_low = 1'b0;
    if (pair_count != prqf_pkg::PAIR_MAX) pair_count++;
    if (verdict && low_pair_count != prqf_pkg::PAIR_MAX) low_pair_count++;
    res = pair_result_t'{verdict, low_pair_count, pair_count,
                         pair_count >= model_cfg.pair_limit};
    return 1'b1;
  endfunction

  task automatic report(input string field, input logic [PAIR_W-1:0] want_v,
                        input logic [PAIR_W-1:0] got_v);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
  endtask

  always @(posedge clk) begin
    pair_result_t got;
    pair_result_t want;
    pair_result_t made;
    logic         accepted;
    accepted = 1'b0;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        accepted = 1'b1;
        got = pair_result_t'{result_ch.pair_is_low, result_ch.low_pair_total,
                             result_ch.pair_total, result_ch.limit_reached};
        n_results++;
        if (got.pair_is_low) n_low++;
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected pair result, expected none, actual pair_total %0d",
                   $time, got.pair_total);
        end else begin
          want = verdict_q.pop_front();
          if (got.pair_is_low !== want.pair_is_low)
            report("pair_is_low", PAIR_W'(want.pair_is_low), PAIR_W'(got.pair_is_low));
          if (got.low_pair_total !== want.low_pair_total)
            report("low_pair_total", want.low_pair_total, got.low_pair_total);
          if (got.pair_total !== want.pair_total)
            report("pair_total", want.pair_total, got.pair_total);
          if (got.limit_reached !== want.limit_reached)
            report("limit_reached", PAIR_W'(want.limit_reached),
                   PAIR_W'(got.limit_reached));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        accepted = 1'b1;
        case (cfg_ch.index)
          prqf_pkg::REG_QUALITY_OFFSET:
            model_cfg.quality_offset = cfg_ch.data[prqf_pkg::QUAL_W-1:0];
          prqf_pkg::REG_LOW_QUALITY_LIMIT:
            model_cfg.low_quality_limit = cfg_ch.data[prqf_pkg::QUAL_W-1:0];
          prqf_pkg::REG_THRESHOLD_IS_COUNT:
            model_cfg.threshold_is_count = cfg_ch.data[0];
          prqf_pkg::REG_COUNT_THRESHOLD:
            model_cfg.count_threshold = cfg_ch.data[prqf_pkg::THR_W-1:0];
          prqf_pkg::REG_FRACTION_Q16:
            model_cfg.fraction_q16 = cfg_ch.data[prqf_pkg::FRAC_W-1:0];
          prqf_pkg::REG_PAIR_LIMIT:
            model_cfg.pair_limit = cfg_ch.data;
          default: ;
        endcase
      end
      if (item_ch.valid && item_ch.ready) begin
        accepted = 1'b1;
        if (score_char(item_ch.quality_char, item_ch.mate, item_ch.read_end, made))
          verdict_q.push_back(row_typed ? row_want : made);
      end
    end
    if (accepted) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no request or result moved for %0d cycles", $time, quiet);
        $display("FAIL");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold on request
  initial begin
    result_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req) begin
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (sink_gaps && $urandom_range(0, 3) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  function automatic stim_row_t char_row(input int qc, input logic m, input logic e);
    stim_row_t r;
    r = '{kind: ROW_CHAR, idx: '0, data: '0, qc: CHAR_W'(qc), mate: m, rend: e,
          typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic stim_row_t typed_row(input int qc, input logic low, input int lows,
                                          input int total);
    stim_row_t r;
    r = char_row(qc, 1'b1, 1'b1);
    r.typed = 1'b1;
    r.want = pair_result_t'{low, PAIR_W'(lows), PAIR_W'(total), 1'b0};
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [PAIR_W-1:0] data);
    stim_row_t r;
    r = '{kind: ROW_REG, idx: idx, data: data, qc: '0, mate: 1'b0, rend: 1'b0,
          typed: 1'b0, want: '0};
    return r;
  endfunction

  task automatic send_char(input logic [CHAR_W-1:0] qc, input logic m, input logic e,
                           input logic typed = 1'b0, input pair_result_t want = '0);
    if (src_gaps && $urandom_range(0, 7) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.quality_char <= qc;
    item_ch.mate <= m;
    item_ch.read_end <= e;
    row_typed <= typed;
    row_want <= want;
    do @(posedge clk); while (!item_ch.ready);
    n_items++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAIR_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    n_regs++;
    @(posedge clk);
  endtask

  // hold requests until every pair result is back and the pipeline is empty
  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [CHAR_W-1:0] pick_char();
    int v;
    if ($urandom_range(0, 3) == 0) return CHAR_W'($urandom_range(0, 255));
    v = int'(model_cfg.quality_offset) + int'(model_cfg.low_quality_limit)
        + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return CHAR_W'(v);
  endfunction

  function automatic int read_len();
    if ($urandom_range(0, 9) == 0) return int'($urandom_range(11, 60));
    return int'($urandom_range(1, 10));
  endfunction

  task automatic send_read(input logic m, input int len);
    logic tag;
    for (int i = 0; i < len; i++) begin
      tag = (i != len - 1 && $urandom_range(0, 3) == 0) ? ~m : m;
      send_char(pick_char(), tag, i == len - 1);
    end
  endtask

  task automatic random_settings();
    logic [PAIR_W-1:0] lim;
    case ($urandom_range(0, 4))
      0: write_reg(prqf_pkg::REG_QUALITY_OFFSET, 48'd33);
      1: write_reg(prqf_pkg::REG_QUALITY_OFFSET, 48'd64);
      2: write_reg(prqf_pkg::REG_QUALITY_OFFSET, 48'd0);
      3: write_reg(prqf_pkg::REG_QUALITY_OFFSET, 48'd127);
      default: write_reg(prqf_pkg::REG_QUALITY_OFFSET, PAIR_W'($urandom_range(0, 127)));
    endcase
    case ($urandom_range(0, 3))
      0: write_reg(prqf_pkg::REG_LOW_QUALITY_LIMIT, 48'd5);
      1: write_reg(prqf_pkg::REG_LOW_QUALITY_LIMIT, 48'd0);
      2: write_reg(prqf_pkg::REG_LOW_QUALITY_LIMIT, 48'd127);
      default: write_reg(prqf_pkg::REG_LOW_QUALITY_LIMIT, PAIR_W'($urandom_range(0, 40)));
    endcase
    write_reg(prqf_pkg::REG_THRESHOLD_IS_COUNT, PAIR_W'($urandom_range(0, 1)));
    case ($urandom_range(0, 2))
      0: write_reg(prqf_pkg::REG_COUNT_THRESHOLD, 48'd1);
      1: write_reg(prqf_pkg::REG_COUNT_THRESHOLD, 48'd65535);
      default: write_reg(prqf_pkg::REG_COUNT_THRESHOLD, PAIR_W'($urandom_range(1, 12)));
    endcase
    case ($urandom_range(0, 3))
      0: write_reg(prqf_pkg::REG_FRACTION_Q16, 48'd32768);
      1: write_reg(prqf_pkg::REG_FRACTION_Q16, 48'd0);
      2: write_reg(prqf_pkg::REG_FRACTION_Q16, 48'd65535);
      default: write_reg(prqf_pkg::REG_FRACTION_Q16, PAIR_W'($urandom_range(0, 65535)));
    endcase
    case ($urandom_range(0, 2))
      0: lim = 48'd1000000;
      1: lim = prqf_pkg::PAIR_MAX;
      default: lim = PAIR_W'(LIMIT_PAIRS) + PAIR_W'($urandom_range(0, 32'hFFFFFF));
    endcase
    write_reg(prqf_pkg::REG_PAIR_LIMIT, lim);
  endtask

  initial begin
    int phase_start;
    item_ch.valid <= 1'b0;
    item_ch.quality_char <= '0;
    item_ch.mate <= 1'b0;
    item_ch.read_end <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    row_typed <= 1'b0;
    row_want <= '0;
    rst <= 1'b1;
    stim_rows = '{
      char_row(38, 1'b0, 1'b0),
      char_row(39, 1'b0, 1'b1),
      typed_row(255, 1'b0, 0, 1),
      typed_row(0, 1'b1, 1, 2),
      char_row(0, 1'b0, 1'b1),
      typed_row(200, 1'b1, 2, 3),
      char_row(0, 1'b0, 1'b1),
      char_row(200, 1'b0, 1'b1),
      typed_row(200, 1'b0, 2, 4),
      char_row(0, 1'b1, 1'b0),
      char_row(0, 1'b1, 1'b0),
      char_row(100, 1'b0, 1'b1),
      typed_row(100, 1'b1, 3, 5),
      reg_row(prqf_pkg::REG_QUALITY_OFFSET, 48'd64),
      reg_row(prqf_pkg::REG_LOW_QUALITY_LIMIT, 48'd0),
      reg_row(prqf_pkg::REG_THRESHOLD_IS_COUNT, 48'd1),
      char_row(64, 1'b0, 1'b0),
      char_row(63, 1'b0, 1'b0),
      typed_row(65, 1'b1, 4, 6),
      reg_row(prqf_pkg::REG_QUALITY_OFFSET, 48'd127),
      reg_row(prqf_pkg::REG_LOW_QUALITY_LIMIT, 48'd127),
      reg_row(prqf_pkg::REG_COUNT_THRESHOLD, 48'd65535),
      char_row(254, 1'b1, 1'b0),
      typed_row(255, 1'b0, 4, 7),
      reg_row(prqf_pkg::REG_THRESHOLD_IS_COUNT, 48'd0),
      reg_row(prqf_pkg::REG_FRACTION_Q16, 48'd0),
      typed_row(128, 1'b1, 5, 8)
    };
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_REG) begin
        drain();
        write_reg(stim_rows[i].idx, stim_rows[i].data);
      end else begin
        send_char(stim_rows[i].qc, stim_rows[i].mate, stim_rows[i].rend,
                  stim_rows[i].typed, stim_rows[i].want);
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      drain();
      random_settings();
      phase_start = n_items;
      if (phase == 1) begin
        hold_req = 1'b1;
        repeat (40) send_char(pick_char(), 1'b1, 1'b1);
      end
      while (n_items - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 15) == 0) src_gaps = !src_gaps;
        if ($urandom_range(0, 15) == 0) sink_gaps = !sink_gaps;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: begin
            send_read(1'b0, read_len());
            send_read(1'b1, read_len());
          end
          7: send_read(1'b1, read_len());
          8: begin
            send_read(1'b0, read_len());
            send_read(1'b0, read_len());
            send_read(1'b1, read_len());
          end
          default: begin
            repeat ($urandom_range(1, 8))
              send_char(CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        $urandom_range(0, 3) == 0);
          end
        endcase
      end
    end

    // run up to a low pair limit with no stalls, then past it
    drain();
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    write_reg(prqf_pkg::REG_PAIR_LIMIT, pair_count + PAIR_W'(LIMIT_STEP));
    for (int i = 0; i < LIMIT_STEP; i++) begin
      if ($urandom_range(0, 1) == 0) send_char(pick_char(), 1'b0, 1'b1);
      send_char(pick_char(), 1'b1, 1'b1);
    end
    repeat (20) send_char(CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    drain();
    write_reg(prqf_pkg::REG_PAIR_LIMIT, prqf_pkg::PAIR_MAX);
    repeat (10) begin
      send_char(pick_char(), 1'b0, 1'b1);
      send_char(pick_char(), 1'b1, 1'b1);
    end

    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Run covered %0d quality characters, %0d register writes and %0d pair results",
             n_items, n_regs, n_results);
    $display("(%0d low pairs, pair limit reached and lifted, %0d mismatches)", n_low, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
